// File: rtl/rket_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rket_pkg
// Types, key codes and lookup tables for the keyboard event translator.
// ----------------------------------------------------------------------------
package rket_pkg;

  typedef enum logic [1:0] {
    CMD_KEY_DOWN = 2'd0,
    CMD_KEY_UP   = 2'd1,
    CMD_INKEY    = 2'd2,
    CMD_GAME     = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] key_code;
    logic       joystick_mode;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  status_byte;
    logic [7:0]  char_byte;
    logic [23:0] game_keys;
    logic        key_interrupt;
  } out_item_t;

  // Keyboard state as seen by the inkey translation.
  typedef struct packed {
    logic       caps;
    logic       kana;
    logic       hit;
    logic       shift;
    logic       ctrl;
    logic       graph;
    logic [7:0] last_scan;
  } kbd_view_t;

  // Host key codes.
  localparam logic [7:0] VK_CAPS      = 8'h14;
  localparam logic [7:0] VK_CAPS_ALT  = 8'hf0;
  localparam logic [7:0] VK_KANA      = 8'h15;
  localparam logic [7:0] VK_KANA_ALT  = 8'hf2;
  localparam logic [7:0] VK_PAUSE     = 8'h13;

  // Scan codes.
  localparam logic [7:0] SC_PAUSE     = 8'h45;
  localparam logic [7:0] SC_INSERT    = 8'hd2;
  localparam logic [7:0] SC_DELETE    = 8'hd3;
  localparam logic [7:0] SC_HOME      = 8'hc7;
  localparam logic [7:0] SC_RIGHT     = 8'hcd;
  localparam logic [7:0] SC_LEFT      = 8'hcb;
  localparam logic [7:0] SC_UP        = 8'hc8;
  localparam logic [7:0] SC_DOWN      = 8'hd0;
  localparam logic [7:0] SC_PAD_ENTER = 8'h9c;
  localparam logic [7:0] SC_PAD_DIV   = 8'hb5;
  localparam logic [7:0] SC_PAD_MUL   = 8'h37;
  localparam logic [7:0] SC_LSHIFT    = 8'h2a;
  localparam logic [7:0] SC_RSHIFT    = 8'h36;
  localparam logic [7:0] SC_LCTRL     = 8'h1d;
  localparam logic [7:0] SC_RCTRL     = 8'h9d;
  localparam logic [7:0] SC_GRAPH     = 8'h38;

  localparam int unsigned GAME_KEY_MAX = 24;

  localparam logic [7:0] GAME_SCAN [0:GAME_KEY_MAX-1] = '{
    8'h10, 8'h11, 8'h12, 8'h1e, 8'h20, 8'h2c, 8'h2d, 8'h2e,
    8'h47, 8'h4b, 8'h4f, 8'h48, 8'h50, 8'h49, 8'h4d, 8'h51,
    8'h01, 8'h02, 8'h4a, 8'h4e, 8'h37, 8'h0f, 8'h39, 8'h1c
  };

  // Character tables: base, shift, graph, ctrl, kana, kana with shift.
  localparam int unsigned ROM_BASE  = 0;
  localparam int unsigned ROM_SHIFT = 1;
  localparam int unsigned ROM_GRAPH = 2;
  localparam int unsigned ROM_CTRL  = 3;
  localparam int unsigned ROM_KANA  = 4;
  localparam int unsigned ROM_KANAS = 5;

  localparam logic [7:0] CHAR_ROM [0:5][0:95] = '{
    '{8'h00,8'h1b,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h30,
      8'h2d,8'h5e,8'h08,8'h09,8'h71,8'h77,8'h65,8'h72,8'h74,8'h79,8'h75,8'h69,
      8'h6f,8'h70,8'h40,8'h5b,8'h0d,8'h00,8'h61,8'h73,8'h64,8'h66,8'h67,8'h68,
      8'h6a,8'h6b,8'h6c,8'h3b,8'h3a,8'h00,8'h00,8'h5d,8'h7a,8'h78,8'h63,8'h76,
      8'h62,8'h6e,8'h6d,8'h2c,8'h2e,8'h2f,8'h00,8'h2a,8'h00,8'h20,8'h00,8'h71,
      8'h72,8'h73,8'h74,8'h75,8'hec,8'heb,8'he2,8'he1,8'h00,8'h13,8'h00,8'h37,
      8'h38,8'h39,8'h2d,8'h34,8'h35,8'h36,8'h2b,8'h31,8'h32,8'h33,8'h30,8'h2e,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h5c,8'h0e,8'h0f,8'h3d,8'hfe,8'h11},
    '{8'h00,8'h1b,8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,8'h27,8'h28,8'h29,8'h30,
      8'h3d,8'h7e,8'h12,8'h09,8'h51,8'h57,8'h45,8'h52,8'h54,8'h59,8'h55,8'h49,
      8'h4f,8'h50,8'h60,8'h7b,8'h0d,8'h00,8'h41,8'h53,8'h44,8'h46,8'h47,8'h48,
      8'h4a,8'h4b,8'h4c,8'h2b,8'h2a,8'h00,8'h00,8'h7d,8'h5a,8'h58,8'h43,8'h56,
      8'h42,8'h4e,8'h4d,8'h3c,8'h3e,8'h3f,8'h00,8'h2a,8'h00,8'h20,8'h00,8'h76,
      8'h77,8'h78,8'h79,8'h7a,8'h00,8'h00,8'h00,8'h00,8'h00,8'h03,8'h00,8'h37,
      8'h38,8'h39,8'h2d,8'h34,8'h35,8'h36,8'h2b,8'h31,8'h32,8'h33,8'h30,8'h2e,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h5f,8'h7c,8'h0e,8'h0f,8'h3d,8'hfe,8'h11},
    '{8'h00,8'h00,8'hf1,8'hf2,8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa,
      8'h8c,8'h8b,8'h00,8'h00,8'he0,8'he1,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,
      8'hf0,8'h8d,8'h8a,8'hfc,8'h00,8'h00,8'h7f,8'he9,8'hea,8'heb,8'hec,8'hed,
      8'hee,8'hef,8'h8e,8'h89,8'hfd,8'h00,8'h00,8'he8,8'h80,8'h81,8'h82,8'h83,
      8'h84,8'h85,8'h86,8'h87,8'h88,8'hfe,8'h00,8'h9b,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h13,8'h00,8'h9a,
      8'h93,8'h97,8'h9c,8'h95,8'h96,8'h94,8'h9d,8'h99,8'h92,8'h98,8'h8f,8'h91,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'hff,8'hfb,8'h0e,8'h0f,8'h90,8'hfe,8'h11},
    '{8'h00,8'h1b,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h30,
      8'h00,8'h1e,8'h08,8'h09,8'h11,8'h17,8'h05,8'h12,8'h14,8'h19,8'h15,8'h09,
      8'h0f,8'h10,8'h40,8'h1b,8'h0d,8'h00,8'h01,8'h13,8'h04,8'h06,8'h07,8'h08,
      8'h0a,8'h0b,8'h0c,8'h3b,8'h3a,8'h00,8'h1c,8'h1d,8'h1a,8'h18,8'h03,8'h16,
      8'h02,8'h0e,8'h0d,8'h00,8'h00,8'h00,8'h00,8'h2a,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'hec,8'heb,8'he2,8'he1,8'h00,8'h03,8'h00,8'h37,
      8'h38,8'h39,8'h2d,8'h34,8'h35,8'h36,8'h2b,8'h31,8'h32,8'h33,8'h30,8'h2e,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h1c,8'h0e,8'h0f,8'h3d,8'hfe,8'h11},
    '{8'h00,8'h1b,8'hc7,8'hcc,8'hb1,8'hb3,8'hb4,8'hb5,8'hd4,8'hd5,8'hd6,8'hdc,
      8'hce,8'hcd,8'h08,8'h09,8'hc0,8'hc3,8'hb2,8'hbd,8'hb6,8'hdd,8'hc5,8'hc6,
      8'hd7,8'hbe,8'hde,8'hdf,8'h0d,8'h00,8'hc1,8'hc4,8'hbc,8'hca,8'hb7,8'hb8,
      8'hcf,8'hc9,8'hd8,8'hda,8'hb9,8'h00,8'h00,8'hd1,8'hc2,8'hbb,8'hbf,8'hcb,
      8'hba,8'hd0,8'hd3,8'hc8,8'hd9,8'hd2,8'h00,8'h2a,8'h00,8'h20,8'h00,8'h71,
      8'h72,8'h73,8'h74,8'h75,8'hec,8'heb,8'he2,8'he1,8'h00,8'h13,8'h00,8'h37,
      8'h38,8'h39,8'h2d,8'h34,8'h35,8'h36,8'h2b,8'h31,8'h32,8'h33,8'h30,8'h2e,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'hdb,8'hb0,8'h0e,8'h0f,8'h3d,8'hfe,8'h11},
    '{8'h00,8'h1b,8'hc7,8'hcc,8'ha7,8'ha9,8'haa,8'hab,8'hac,8'had,8'hae,8'ha6,
      8'hce,8'hcd,8'h12,8'h09,8'hc0,8'hc3,8'ha8,8'hbd,8'hb6,8'hdd,8'hc5,8'hc6,
      8'hd7,8'hbe,8'hde,8'ha2,8'h0d,8'h00,8'hc1,8'hc4,8'hbc,8'hca,8'hb7,8'hb8,
      8'hcf,8'hc9,8'hd8,8'hda,8'hb9,8'h00,8'h00,8'ha3,8'haf,8'hbb,8'hbf,8'hcb,
      8'hba,8'hd0,8'hd3,8'ha4,8'ha1,8'ha5,8'h00,8'h2a,8'h00,8'h20,8'h00,8'h76,
      8'h77,8'h78,8'h79,8'h7a,8'h00,8'h00,8'h00,8'h00,8'h00,8'h03,8'h00,8'h37,
      8'h38,8'h39,8'h2d,8'h34,8'h35,8'h36,8'h2b,8'h31,8'h32,8'h33,8'h30,8'h2e,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'hdb,8'hb0,8'h0e,8'h0f,8'h3d,8'hfe,8'h11}
  };

  // Host key code to scan code; unmapped keys give zero.
  function automatic logic [7:0] scan_lookup(input logic [7:0] k);
    logic [7:0] s;
    unique case (k)
      8'h03: s = 8'h45; 8'h08: s = 8'h0e; 8'h09: s = 8'h0f; 8'h0d: s = 8'h1c;
      8'h10: s = 8'h2a; 8'h11: s = 8'h1d; 8'h12: s = 8'h38; 8'h13: s = 8'h45;
      8'h1b: s = 8'h01; 8'h1c: s = 8'h5e; 8'h20: s = 8'h39; 8'h21: s = 8'h5b;
      8'h22: s = 8'h5c; 8'h23: s = 8'h5f; 8'h24: s = 8'hc7; 8'h25: s = 8'hcb;
      8'h26: s = 8'hc8; 8'h27: s = 8'hcd; 8'h28: s = 8'hd0; 8'h2d: s = 8'hd2;
      8'h2e: s = 8'hd3; 8'h30: s = 8'h0b; 8'h31: s = 8'h02; 8'h32: s = 8'h03;
      8'h33: s = 8'h04; 8'h34: s = 8'h05; 8'h35: s = 8'h06; 8'h36: s = 8'h07;
      8'h37: s = 8'h08; 8'h38: s = 8'h09; 8'h39: s = 8'h0a; 8'h41: s = 8'h1e;
      8'h42: s = 8'h30; 8'h43: s = 8'h2e; 8'h44: s = 8'h20; 8'h45: s = 8'h12;
      8'h46: s = 8'h21; 8'h47: s = 8'h22; 8'h48: s = 8'h23; 8'h49: s = 8'h17;
      8'h4a: s = 8'h24; 8'h4b: s = 8'h25; 8'h4c: s = 8'h26; 8'h4d: s = 8'h32;
      8'h4e: s = 8'h31; 8'h4f: s = 8'h18; 8'h50: s = 8'h19; 8'h51: s = 8'h10;
      8'h52: s = 8'h13; 8'h53: s = 8'h1f; 8'h54: s = 8'h14; 8'h55: s = 8'h16;
      8'h56: s = 8'h2f; 8'h57: s = 8'h11; 8'h58: s = 8'h2d; 8'h59: s = 8'h15;
      8'h5a: s = 8'h2c; 8'h60: s = 8'h52; 8'h61: s = 8'h4f; 8'h62: s = 8'h50;
      8'h63: s = 8'h51; 8'h64: s = 8'h4b; 8'h65: s = 8'h4c; 8'h66: s = 8'h4d;
      8'h67: s = 8'h47; 8'h68: s = 8'h48; 8'h69: s = 8'h49; 8'h6a: s = 8'h37;
      8'h6b: s = 8'h4e; 8'h6c: s = 8'h33; 8'h6d: s = 8'h4a; 8'h6e: s = 8'h53;
      8'h6f: s = 8'h35; 8'h70: s = 8'h3b; 8'h71: s = 8'h3c; 8'h72: s = 8'h3d;
      8'h73: s = 8'h3e; 8'h74: s = 8'h3f; 8'h75: s = 8'h40; 8'h76: s = 8'h41;
      8'h77: s = 8'h42; 8'h78: s = 8'h43; 8'h79: s = 8'h44; 8'h7a: s = 8'h57;
      8'h7b: s = 8'h58; 8'h91: s = 8'h38; 8'h92: s = 8'h5d; 8'hba: s = 8'h28;
      8'hbb: s = 8'h27; 8'hbc: s = 8'h33; 8'hbd: s = 8'h0c; 8'hbe: s = 8'h34;
      8'hbf: s = 8'h35; 8'hc0: s = 8'h1a; 8'hdb: s = 8'h1b; 8'hdc: s = 8'h5a;
      8'hdd: s = 8'h2b; 8'hde: s = 8'h0d; 8'he2: s = 8'h59;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic joy_mapped(input logic [7:0] s);
    return (s == 8'h1c) || (s == 8'h2c) || (s == 8'h2d) || (s == 8'h2e) ||
           (s == 8'h2f) || (s == 8'h39) || (s == 8'h48) || (s == 8'h4b) ||
           (s == 8'h4d) || (s == 8'h50);
  endfunction

endpackage

// File: rtl/rket_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rket_state
// Pressed map, lock toggles, pending key and interrupt flag, with their
// update for key events and inkey queries.
// ----------------------------------------------------------------------------
module rket_state #(
  parameter int unsigned GAME_KEY_COUNT = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                upd_en,
  input  rket_pkg::in_item_t  item,
  input  logic                pause_release,
  output rket_pkg::kbd_view_t view,
  output logic [23:0]         game_keys,
  output logic                irq_nxt
);
  import rket_pkg::*;

  logic [255:0] pressed_r, pressed_nxt;
  logic         caps_r, caps_nxt, kana_r, kana_nxt, hit_r, hit_nxt, irq_r;
  logic [7:0]   last_r, last_nxt, scan;

  assign scan = scan_lookup(item.key_code);

  always_comb begin
    pressed_nxt = pressed_r;
    caps_nxt    = caps_r;
    kana_nxt    = kana_r;
    hit_nxt     = hit_r;
    irq_nxt     = irq_r;
    last_nxt    = last_r;
    unique case (cmd_t'(item.cmd))
      CMD_KEY_DOWN: begin
        if (item.key_code == VK_CAPS || item.key_code == VK_CAPS_ALT) begin
          caps_nxt = ~caps_r;
        end else if (item.key_code == VK_KANA || item.key_code == VK_KANA_ALT) begin
          kana_nxt = ~kana_r;
        end else begin
          last_nxt = scan;
          if (scan != 8'h00) begin
            pressed_nxt[scan] = 1'b1;
            irq_nxt           = 1'b1;
            hit_nxt           = 1'b1;
          end
        end
      end
      CMD_KEY_UP: begin
        pressed_nxt[scan] = 1'b0;
        // Releasing the pause key leaves the pending key for the next inkey.
        if (item.key_code != VK_PAUSE) begin
          irq_nxt  = 1'b1;
          hit_nxt  = 1'b0;
          last_nxt = 8'h00;
        end
      end
      CMD_INKEY: begin
        if (pause_release) begin
          irq_nxt  = 1'b1;
          hit_nxt  = 1'b0;
          last_nxt = 8'h00;
        end
      end
      CMD_GAME: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= '0;
      caps_r    <= 1'b0;
      kana_r    <= 1'b0;
      hit_r     <= 1'b0;
      irq_r     <= 1'b0;
      last_r    <= 8'h00;
    end else if (upd_en) begin
      pressed_r <= pressed_nxt;
      caps_r    <= caps_nxt;
      kana_r    <= kana_nxt;
      hit_r     <= hit_nxt;
      irq_r     <= irq_nxt;
      last_r    <= last_nxt;
    end
  end

  always_comb begin
    view.caps      = caps_r;
    view.kana      = kana_r;
    view.hit       = hit_r;
    view.shift     = pressed_r[SC_LSHIFT] | pressed_r[SC_RSHIFT];
    view.ctrl      = pressed_r[SC_LCTRL] | pressed_r[SC_RCTRL];
    view.graph     = pressed_r[SC_GRAPH];
    view.last_scan = last_r;
  end

  always_comb begin
    game_keys = '0;
    for (int i = 0; i < GAME_KEY_COUNT; i++) begin
      game_keys[GAME_KEY_MAX-1-i] = pressed_r[GAME_SCAN[i]];
    end
  end

endmodule

// File: rtl/rket_inkey.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rket_inkey
// Builds the active-low modifier byte and translates the pending key.
// ----------------------------------------------------------------------------
module rket_inkey (
  input  rket_pkg::kbd_view_t view,
  input  logic                joy,
  output logic [7:0]          status_byte,
  output logic [7:0]          char_byte,
  output logic                pause_release
);
  import rket_pkg::*;

  logic [7:0] s, sc, c, rc;
  logic [6:0] key;
  logic       key_ok;
  logic [2:0] rom_sel;

  assign sc = view.last_scan;

  always_comb begin
    key_ok = 1'b0;
    key    = 7'd0;
    if (sc == SC_PAD_ENTER) begin
      key_ok = 1'b1;
      key    = 7'h1c;
    end else if (sc != 8'h00 && sc < 8'h60) begin
      key_ok = 1'b1;
      key    = sc[6:0];
    end
  end

  always_comb begin
    priority if (view.kana) begin
      rom_sel = view.shift ? 3'(ROM_KANAS) : 3'(ROM_KANA);
    end else if (view.ctrl) begin
      rom_sel = 3'(ROM_CTRL);
    end else if (view.graph) begin
      rom_sel = 3'(ROM_GRAPH);
    end else begin
      rom_sel = view.shift ? 3'(ROM_SHIFT) : 3'(ROM_BASE);
    end
  end

  always_comb begin
    rc = CHAR_ROM[rom_sel][key];
    // Caps lock flips the case of letters from the plain tables only.
    if (view.caps && !view.kana && !view.ctrl && !view.graph &&
        ((rc >= 8'h61 && rc <= 8'h7a) || (rc >= 8'h41 && rc <= 8'h5a))) begin
      rc = rc ^ 8'h20;
    end
  end

  always_comb begin
    s = 8'hff;
    if (view.ctrl)  s[0] = 1'b0;
    if (view.shift) s[1] = 1'b0;
    if (view.kana)  s[2] = 1'b0;
    if (view.caps)  s[3] = 1'b0;
    if (view.graph) s[4] = 1'b0;
    c             = 8'h00;
    pause_release = 1'b0;
    if (view.hit && !(joy && joy_mapped(sc))) begin
      if ((sc >= 8'h3b && sc <= 8'h3f) || (sc >= 8'h47 && sc <= 8'h53) ||
          sc == SC_PAD_MUL || sc == SC_PAD_DIV) begin
        s[7] = 1'b0;
      end
      if (sc == SC_RIGHT || sc == SC_LEFT || sc == SC_UP || sc == SC_DOWN) begin
        // With the joystick on, arrows report no key at all.
        if (!joy) begin
          s[6] = 1'b0;
          c = (sc == SC_RIGHT) ? 8'h1c : (sc == SC_LEFT) ? 8'h1d :
              (sc == SC_UP) ? 8'h1e : 8'h1f;
        end
      end else begin
        s[6] = 1'b0;
        priority if (sc == SC_INSERT) begin
          c = 8'h12;
        end else if (sc == SC_DELETE) begin
          c = 8'h08;
        end else if (sc == SC_HOME) begin
          c = view.shift ? 8'h0c : 8'h0b;
        end else if (key_ok) begin
          c = rc;
        end else begin
          c = 8'h00;
        end
        pause_release = (sc == SC_PAUSE);
      end
    end
    status_byte = s;
    char_byte   = c;
  end

endmodule

// File: rtl/rket_obuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rket_obuf
// Result register with a skid stage, so a new beat can be taken while a
// finished result still waits downstream.
// ----------------------------------------------------------------------------
module rket_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rket_pkg::out_item_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output rket_pkg::out_item_t out_data
);
  import rket_pkg::*;

  logic      out_valid_r, skid_valid_r, pop;
  out_item_t out_data_r, skid_data_r;

  assign pop       = out_valid_r & ~out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_data_r  <= push_data;
        skid_valid_r <= 1'b1;
      end else begin
        out_data_r  <= push_data;
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// File: rtl/retro_keyboard_event_translator_unit.sv
`timescale 1ns / 1ps
// A query's result is registered in the output buffer, or in its skid stage.
// One beat is taken per cycle while in_stall is low; key events give no result.
// The result side holds two results; input stalls only when both are full.
// Reset (synchronous, active low) clears the pressed map, locks, pending
// key and flags.
// ----------------------------------------------------------------------------
// retro_keyboard_event_translator_unit
// Keyboard event translator: key events update state, queries answer.
// ----------------------------------------------------------------------------
module retro_keyboard_event_translator_unit #(
  parameter int unsigned GAME_KEY_COUNT = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rket_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rket_pkg::out_item_t out_data
);
  import rket_pkg::*;

  logic        accept, full, pause_release, irq_nxt, is_query;
  kbd_view_t   view;
  logic [23:0] game_keys;
  logic [7:0]  status_byte, char_byte;
  out_item_t   res;

  assign in_stall = full;
  assign accept   = in_valid & ~full;
  assign is_query = in_data.cmd[1];

  rket_state #(.GAME_KEY_COUNT(GAME_KEY_COUNT)) u_state (
    .clk           (clk),
    .rst_n         (rst_n),
    .upd_en        (accept),
    .item          (in_data),
    .pause_release (pause_release),
    .view          (view),
    .game_keys     (game_keys),
    .irq_nxt       (irq_nxt)
  );

  rket_inkey u_inkey (
    .view          (view),
    .joy           (in_data.joystick_mode),
    .status_byte   (status_byte),
    .char_byte     (char_byte),
    .pause_release (pause_release)
  );

  always_comb begin
    res.key_interrupt = irq_nxt;
    if (cmd_t'(in_data.cmd) == CMD_INKEY) begin
      res.status_byte = status_byte;
      res.char_byte   = char_byte;
      res.game_keys   = '0;
    end else begin
      res.status_byte = 8'h00;
      res.char_byte   = 8'h00;
      res.game_keys   = game_keys;
    end
  end

  rket_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept & is_query),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
